// File: src/text_mode_pixel_generator_macros.svh
// assertion helpers used by the port checker file
`ifndef TEXT_MODE_PIXEL_GENERATOR_MACROS_SVH
`define TEXT_MODE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define TMPG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// next-cycle implication
`define TMPG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

// File: src/tmpg_pkg.sv
`timescale 1ns / 1ps

package tmpg_pkg;

   // field widths
   localparam int ADDR_W  = 13;
   localparam int VRAM_W  = 16;
   localparam int GLYPH_W = 8;
   localparam int CODE_W  = 9;
   localparam int CMD_W   = 2;
   localparam int COLOR_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int HALF_BIT = 11;

   // raster counter widths
   localparam int PIXEL_W = 4;
   localparam int COL_W   = 7;
   localparam int SCAN_W  = 4;
   localparam int ROW_W   = 5;

   localparam int CELL_WIDTH = 10;

   // parameter defaults
   localparam int COLUMNS_DEF        = 80;
   localparam int ROWS_DEF           = 28;
   localparam int LINES_PER_CELL_DEF = 15;

   // commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_VRAM  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GLYPH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_VIDEO     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_UNDERLINE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_COLUMN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_ROW       = 3'd4;

   // pixel colors
   localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd0;
   localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd1;
   localparam logic [COLOR_W-1:0] COLOR_HALF  = 2'd2;

   typedef struct packed {
      logic display_enable;
      logic invert_video;
      logic cursor_underline;
   } cfg_type;

   // raster position of one pixel as it travels down the pipeline
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [SCAN_W-1:0]  scan;
      logic               at_cursor;
      logic               last_scan;
      logic               eol;
      logic               eof;
   } pos_type;

endpackage

// File: src/tmpg_ram.sv
`timescale 1ns / 1ps

module tmpg_ram import tmpg_pkg::*; #(
   parameter int DATA_W = VRAM_W,
   parameter int AW     = ADDR_W
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [2**AW];
   logic [DATA_W-1:0] rd_data_ff;

   // read-first: a read and a write at the same edge return the old word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tmpg_raster.sv
`timescale 1ns / 1ps

module tmpg_raster import tmpg_pkg::*; #(
   parameter int COLUMNS        = COLUMNS_DEF,
   parameter int ROWS           = ROWS_DEF,
   parameter int LINES_PER_CELL = LINES_PER_CELL_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [CSR_DATA_W-1:0] cursor_column,
   input  logic [CSR_DATA_W-1:0] cursor_row,
   output logic [ADDR_W-1:0]     cell_addr,
   output pos_type               pos
);

   logic [PIXEL_W-1:0] pixel_ff, pixel_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  row_base_ff, row_base_in;
   logic               pixel_last, col_last, scan_last, row_last;

   assign pixel_last = (pixel_ff == PIXEL_W'(CELL_WIDTH - 1));
   assign col_last   = (col_ff == COL_W'(COLUMNS - 1));
   assign scan_last  = (scan_ff == SCAN_W'(LINES_PER_CELL - 1));
   assign row_last   = (row_ff == ROW_W'(ROWS - 1));

   always_comb begin
      pixel_in    = pixel_ff;
      col_in      = col_ff;
      scan_in     = scan_ff;
      row_in      = row_ff;
      row_base_in = row_base_ff;
      if (advance) begin
         pixel_in = pixel_ff + 1'b1;
         if (pixel_last) begin
            pixel_in = '0;
            col_in   = col_ff + 1'b1;
            if (col_last) begin
               col_in  = '0;
               scan_in = scan_ff + 1'b1;
               if (scan_last) begin
                  scan_in     = '0;
                  row_in      = row_ff + 1'b1;
                  row_base_in = row_base_ff + ADDR_W'(COLUMNS);
                  if (row_last) begin
                     row_in      = '0;
                     row_base_in = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff    <= '0;
         col_ff      <= '0;
         scan_ff     <= '0;
         row_ff      <= '0;
         row_base_ff <= '0;
      end else begin
         pixel_ff    <= pixel_in;
         col_ff      <= col_in;
         scan_ff     <= scan_in;
         row_ff      <= row_in;
         row_base_ff <= row_base_in;
      end
   end

   // row base is kept as a running sum, no multiplier
   assign cell_addr = row_base_ff + ADDR_W'(col_ff);

   always_comb begin
      pos.pixel     = pixel_ff;
      pos.scan      = scan_ff;
      pos.at_cursor = (CSR_DATA_W'(col_ff) == cursor_column) &&
                      (CSR_DATA_W'(row_ff) == cursor_row);
      pos.last_scan = scan_last;
      pos.eol       = pixel_last && col_last;
      pos.eof       = pixel_last && col_last && scan_last && row_last;
   end

endmodule

// File: src/tmpg_shade.sv
`timescale 1ns / 1ps

module tmpg_shade import tmpg_pkg::*; (
   input  pos_type              pos,
   input  cfg_type              cfg,
   input  logic [GLYPH_W-1:0]   glyph_bits,
   input  logic                 half_lit,
   output logic [COLOR_W-1:0]   color
);

   logic               in_glyph;
   logic [PIXEL_W-1:0] bit_pos;
   logic               level;

   assign in_glyph = (pos.pixel >= PIXEL_W'(1)) && (pos.pixel <= PIXEL_W'(GLYPH_W));
   assign bit_pos  = pos.pixel - 1'b1;

   always_comb begin
      level = cfg.invert_video;
      if (in_glyph) begin
         level = glyph_bits[bit_pos[2:0]] ^ cfg.invert_video;
      end
      if (pos.at_cursor) begin
         if (!cfg.cursor_underline) begin
            level = ~level;
         end else if (pos.last_scan) begin
            level = 1'b1;
         end
      end
      if (!cfg.display_enable || level) begin
         color = COLOR_BLACK;
      end else if (half_lit) begin
         color = COLOR_HALF;
      end else begin
         color = COLOR_WHITE;
      end
   end

endmodule

// File: src/text_mode_pixel_generator.sv
`timescale 1ns / 1ps

// Text-mode pixel generator: a pixel-tick beat produces one pixel of the raster
// (COLUMNS x ROWS cells of 10 x LINES_PER_CELL pixels) on the rsp channel,
// while video RAM and glyph write beats load the two on-chip memories and
// produce nothing. One beat is taken every clock when the rsp side keeps up;
// a pixel appears after the chained reads of video RAM and then the glyph
// store, plus the output register. Neither memory is cleared at reset, so a
// cell or glyph row must be written before it is displayed. The user must write
// registers through the csr port only while no beat is in flight; the block
// itself does not enforce it.

module text_mode_pixel_generator import tmpg_pkg::*; #(
   parameter int COLUMNS        = COLUMNS_DEF,
   parameter int ROWS           = ROWS_DEF,
   parameter int LINES_PER_CELL = LINES_PER_CELL_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel tick and write beats
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [VRAM_W-1:0]     req_write_data,
   // pixel beats
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COLOR_W-1:0]    rsp_pixel_color,
   output logic                  rsp_last_in_line,
   output logic                  rsp_last_in_frame,
   // register writes
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // configuration registers
   cfg_type               cfg_ff, cfg_in;
   logic [CSR_DATA_W-1:0] cursor_column_ff, cursor_column_in;
   logic [CSR_DATA_W-1:0] cursor_row_ff, cursor_row_in;

   // pipeline control
   logic accept, tick, pipe_en, out_free;

   // stage 1: video RAM word is being read
   logic    s1_valid_ff, s1_valid_in;
   pos_type s1_pos_ff, s1_pos_in;
   // stage 2: glyph row is being read
   logic    s2_valid_ff, s2_valid_in;
   pos_type s2_pos_ff, s2_pos_in;
   logic    s2_half_ff, s2_half_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic               rsp_eol_ff, rsp_eol_in;
   logic               rsp_eof_ff, rsp_eof_in;

   logic [ADDR_W-1:0]  cell_addr;
   pos_type            raster_pos;
   logic [VRAM_W-1:0]  vram_word;
   logic [ADDR_W-1:0]  glyph_addr;
   logic [GLYPH_W-1:0] glyph_bits;
   logic [COLOR_W-1:0] shade_color;

   // csr decode
   always_comb begin
      cfg_in           = cfg_ff;
      cursor_column_in = cursor_column_ff;
      cursor_row_in    = cursor_row_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISPLAY_ENABLE:   cfg_in.display_enable   = csr_write_data[0];
            CSR_INVERT_VIDEO:     cfg_in.invert_video     = csr_write_data[0];
            CSR_CURSOR_UNDERLINE: cfg_in.cursor_underline = csr_write_data[0];
            CSR_CURSOR_COLUMN:    cursor_column_in        = csr_write_data;
            CSR_CURSOR_ROW:       cursor_row_in           = csr_write_data;
            default: ;  // writes to unused indexes are dropped
         endcase
      end
   end

   // both stages and both memory reads move together; they only stop when a pixel sits in
   // stage 2 and the output register is still held by the consumer
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pipe_en   = out_free || !s2_valid_ff;
   assign req_stall = !pipe_en;
   assign accept    = req_valid && pipe_en;
   assign tick      = accept && (req_command == CMD_TICK);

   tmpg_raster #(
      .COLUMNS        (COLUMNS),
      .ROWS           (ROWS),
      .LINES_PER_CELL (LINES_PER_CELL)
   ) u_raster (
      .clock         (clock),
      .reset         (reset),
      .advance       (tick),
      .cursor_column (cursor_column_ff),
      .cursor_row    (cursor_row_ff),
      .cell_addr     (cell_addr),
      .pos           (raster_pos)
   );

   // video RAM: read at the tick, written by video RAM write beats
   tmpg_ram #(
      .DATA_W (VRAM_W),
      .AW     (ADDR_W)
   ) u_vram (
      .clock   (clock),
      .rd_en   (pipe_en),
      .rd_addr (cell_addr),
      .rd_data (vram_word),
      .wr_en   (accept && (req_command == CMD_VRAM)),
      .wr_addr (req_address),
      .wr_data (req_write_data)
   );

   // glyph row address: character code above the scan line
   assign glyph_addr = {vram_word[CODE_W-1:0], s1_pos_ff.scan};

   // glyph store: read at the next pipeline advance after the tick; a glyph write beat that
   // follows a tick lands on that same edge and the read-first memory keeps
   // the older row for that tick, so beat order is preserved
   tmpg_ram #(
      .DATA_W (GLYPH_W),
      .AW     (ADDR_W)
   ) u_glyph (
      .clock   (clock),
      .rd_en   (pipe_en),
      .rd_addr (glyph_addr),
      .rd_data (glyph_bits),
      .wr_en   (accept && (req_command == CMD_GLYPH)),
      .wr_addr (req_address),
      .wr_data (req_write_data[GLYPH_W-1:0])
   );

   tmpg_shade u_shade (
      .pos        (s2_pos_ff),
      .cfg        (cfg_ff),
      .glyph_bits (glyph_bits),
      .half_lit   (s2_half_ff),
      .color      (shade_color)
   );

   // pipeline advance
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_pos_in    = s1_pos_ff;
      s2_valid_in  = s2_valid_ff;
      s2_pos_in    = s2_pos_ff;
      s2_half_in   = s2_half_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_eol_in   = rsp_eol_ff;
      rsp_eof_in   = rsp_eof_ff;
      if (pipe_en) begin
         s1_valid_in = tick;
         s1_pos_in   = raster_pos;
         s2_valid_in = s1_valid_ff;
         s2_pos_in   = s1_pos_ff;
         s2_half_in  = vram_word[HALF_BIT];
      end
      // output register loads whenever it is empty or being drained
      if (out_free) begin
         rsp_valid_in = s2_valid_ff;
         rsp_color_in = shade_color;
         rsp_eol_in   = s2_pos_ff.eol;
         rsp_eof_in   = s2_pos_ff.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         cursor_column_ff <= '0;
         cursor_row_ff    <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff           <= cfg_in;
         cursor_column_ff <= cursor_column_in;
         cursor_row_ff    <= cursor_row_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_pos_ff    <= s1_pos_in;
      s2_pos_ff    <= s2_pos_in;
      s2_half_ff   <= s2_half_in;
      rsp_color_ff <= rsp_color_in;
      rsp_eol_ff   <= rsp_eol_in;
      rsp_eof_ff   <= rsp_eof_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_last_in_line  = rsp_eol_ff;
   assign rsp_last_in_frame = rsp_eof_ff;

endmodule

// File: src/tmpg_port_check.sv
`timescale 1ns / 1ps
`include "text_mode_pixel_generator_macros.svh"

module tmpg_port_check import tmpg_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [COLOR_W-1:0] rsp_pixel_color,
   input logic               rsp_last_in_line,
   input logic               rsp_last_in_frame
);

   // pixel beat payload as one vector
   logic [COLOR_W+1:0] rsp_beat;

   assign rsp_beat = {rsp_pixel_color, rsp_last_in_line, rsp_last_in_frame};

   // a stalled pixel beat stays and holds its payload
   `TMPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat))

   // the frame ends only on the end of a scan line
   `TMPG_ASSERT_IMP(a_eof_eol, clock, reset, rsp_valid && rsp_last_in_frame, rsp_last_in_line)

   // only the three defined colors appear
   `TMPG_ASSERT_IMP(a_color, clock, reset, rsp_valid, rsp_pixel_color <= COLOR_HALF)

   // the input stalls only behind a stalled pixel beat
   `TMPG_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // no pixel beat right after reset
   `TMPG_ASSERT_IMP(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind text_mode_pixel_generator tmpg_port_check u_port_check (.*);

// File: tb/sv/text_mode_pixel_generator_tb.sv
`timescale 1ns / 1ps

module text_mode_pixel_generator_tb;
   import tmpg_pkg::*;

   // command code with no function, the block drops it
   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

   // screen geometry at the default parameters
   localparam int SCREEN_WORDS = COLUMNS_DEF * ROWS_DEF;
   localparam int LAST_SCAN    = LINES_PER_CELL_DEF - 1;

   // settle time after the last pixel beat, covers the two read stages and the output register
   localparam int SETTLE_CYCLES = 8;

   // glyph codes that get all their scan lines written before any pixel is drawn
   localparam logic [CODE_W-1:0] GLYPH_CODES [8] = '{
      9'd0, 9'd511, 9'd170, 9'd341, 9'd1, 9'd256, 9'd77, 9'd300
   };

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               eol;
      logic               eof;
   } pixel_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command = CMD_TICK;
   logic [ADDR_W-1:0]     req_address = '0;
   logic [VRAM_W-1:0]     req_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COLOR_W-1:0]    rsp_pixel_color;
   logic                  rsp_last_in_line;
   logic                  rsp_last_in_frame;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // pixels predicted but not yet seen on the rsp side, oldest first
   pixel_beat_type expected_pixels [$];
   pixel_beat_type want_pixel;
   int             err_count = 0;

   // shadow copy of the two memories
   logic [VRAM_W-1:0]  vram_copy  [0:8191];
   logic [GLYPH_W-1:0] glyph_copy [0:8191];

   // raster position of the next pixel tick
   logic [PIXEL_W-1:0] ras_pixel = '0;
   logic [COL_W-1:0]   ras_col   = '0;
   logic [SCAN_W-1:0]  ras_scan  = '0;
   logic [ROW_W-1:0]   ras_row   = '0;
   int                 lines_done = 0;

   // register shadow, all zero out of reset
   logic       cfg_display   = 1'b0;
   logic       cfg_invert    = 1'b0;
   logic       cfg_underline = 1'b0;
   logic [7:0] cfg_cur_col   = '0;
   logic [7:0] cfg_cur_row   = '0;

   // traffic shaping knobs, in percent of cycles
   int gap_pct   = 0;
   int stall_pct = 0;
   // cycles left in a forced rsp hold-off
   int hold_left = 0;

   text_mode_pixel_generator u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_in_line  (rsp_last_in_line),
      .rsp_last_in_frame (rsp_last_in_frame),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   // rsp side back-pressure: a counted hold-off wins over random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // compare every accepted pixel beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_pixels.size() == 0) begin
            $error("pixel beat with nothing expected");
            err_count++;
         end else begin
            want_pixel = expected_pixels.pop_front();
            if (rsp_pixel_color !== want_pixel.color) begin
               $error("pixel_color: expected %0d, actual %0d",
                      want_pixel.color, rsp_pixel_color);
               err_count++;
            end
            if (rsp_last_in_line !== want_pixel.eol) begin
               $error("last_in_line: expected %0d, actual %0d",
                      want_pixel.eol, rsp_last_in_line);
               err_count++;
            end
            if (rsp_last_in_frame !== want_pixel.eof) begin
               $error("last_in_frame: expected %0d, actual %0d",
                      want_pixel.eof, rsp_last_in_frame);
               err_count++;
            end
         end
      end
   end

   // apply one accepted beat to the shadow state; a tick queues its pixel
   task automatic raster_predict(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                 input logic [VRAM_W-1:0] data);
      logic [VRAM_W-1:0]  word;
      logic [GLYPH_W-1:0] row_bits;
      logic [ADDR_W-1:0]  glyph_addr;
      logic               level;
      int                 word_index;
      pixel_beat_type     pix;
      if (cmd == CMD_VRAM) begin
         vram_copy[addr] = data;
      end else if (cmd == CMD_GLYPH) begin
         glyph_copy[addr] = data[GLYPH_W-1:0];
      end else if (cmd == CMD_TICK) begin
         word_index = ras_row * COLUMNS_DEF + ras_col;
         word = vram_copy[word_index[ADDR_W-1:0]];
         // glyph row address wraps at the store size
         glyph_addr = {word[CODE_W-1:0], 4'b0000} + ras_scan;
         row_bits = glyph_copy[glyph_addr];

         // side columns show the invert level, the inner eight the glyph row
         level = cfg_invert;
         if (ras_pixel >= 1 && ras_pixel <= 8)
            level = row_bits[ras_pixel - 1] ^ cfg_invert;

         if (ras_col == cfg_cur_col && ras_row == cfg_cur_row) begin
            if (!cfg_underline)
               level = ~level;
            else if (ras_scan == LAST_SCAN)
               level = 1'b1;
         end

         if (!cfg_display || level)
            pix.color = COLOR_BLACK;
         else if (word[HALF_BIT])
            pix.color = COLOR_HALF;
         else
            pix.color = COLOR_WHITE;
         pix.eol = (ras_pixel == CELL_WIDTH - 1) && (ras_col == COLUMNS_DEF - 1);
         pix.eof = pix.eol && (ras_scan == LAST_SCAN) && (ras_row == ROWS_DEF - 1);
         expected_pixels.push_back(pix);
         if (pix.eol)
            lines_done++;

         // step the raster, wrapping to the top after the last pixel
         if (ras_pixel == CELL_WIDTH - 1) begin
            ras_pixel = '0;
            if (ras_col == COLUMNS_DEF - 1) begin
               ras_col = '0;
               if (ras_scan == LAST_SCAN) begin
                  ras_scan = '0;
                  if (ras_row == ROWS_DEF - 1)
                     ras_row = '0;
                  else
                     ras_row = ras_row + 1'b1;
               end else begin
                  ras_scan = ras_scan + 1'b1;
               end
            end else begin
               ras_col = ras_col + 1'b1;
            end
         end else begin
            ras_pixel = ras_pixel + 1'b1;
         end
      end
   endtask

   // offer one beat and hold it until taken; valid stays high on return
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [VRAM_W-1:0] data);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_address    <= addr;
      req_write_data <= data;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      raster_predict(cmd, addr, data);
   endtask

   // random sender gaps with valid low, repeated while the draw stays under gap_pct
   task automatic sender_gaps();
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // stop sending, let every pixel drain and trailing writes settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
   endtask

   // write all five registers; only called with the block idle
   task automatic program_regs(input logic de, input logic iv, input logic cu,
                               input logic [7:0] cc, input logic [7:0] cr);
      // junk in the upper bits of the one-bit registers must be ignored
      csr_write(CSR_DISPLAY_ENABLE,   {7'($urandom_range(127)), de});
      csr_write(CSR_INVERT_VIDEO,     {7'($urandom_range(127)), iv});
      csr_write(CSR_CURSOR_UNDERLINE, {7'($urandom_range(127)), cu});
      csr_write(CSR_CURSOR_COLUMN,    cc);
      csr_write(CSR_CURSOR_ROW,       cr);
      csr_write_enable <= 1'b0;
      cfg_display   = de;
      cfg_invert    = iv;
      cfg_underline = cu;
      cfg_cur_col   = cc;
      cfg_cur_row   = cr;
   endtask

   // random register setting; the cursor lands near the raster often enough to be seen
   task automatic random_regs();
      int c;
      int r;
      case ($urandom_range(3))
         0: begin
            c = ras_col + $urandom_range(0, 3);
            if (c > COLUMNS_DEF - 1)
               c = COLUMNS_DEF - 1;
            r = ras_row;
         end
         1: begin
            c = $urandom_range(0, COLUMNS_DEF - 1);
            r = $urandom_range(0, ROWS_DEF - 1);
         end
         // cursor off screen, never matches a cell
         2: begin
            c = $urandom_range(COLUMNS_DEF, 255);
            r = $urandom_range(0, 255);
         end
         default: begin
            c = $urandom_range(1) ? 255 : 0;
            r = $urandom_range(1) ? 255 : 0;
         end
      endcase
      program_regs($urandom_range(0, 4) != 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   c[7:0], r[7:0]);
   endtask

   // fill every glyph row of the code set and every word of the top cell row
   task automatic test_load_memories();
      logic [GLYPH_W-1:0] glyph_row;
      logic [VRAM_W-1:0]  word;
      foreach (GLYPH_CODES[k]) begin
         for (int s = 0; s < LINES_PER_CELL_DEF; s++) begin
            if (GLYPH_CODES[k] == 9'd0)
               glyph_row = 8'h00;
            else if (GLYPH_CODES[k] == 9'd511)
               glyph_row = 8'hff;
            else
               glyph_row = 8'($urandom_range(255));
            send_beat(CMD_GLYPH, ADDR_W'({GLYPH_CODES[k], 4'b0000} + s),
                      {8'($urandom_range(255)), glyph_row});
         end
      end
      for (int a = 0; a < COLUMNS_DEF; a++) begin
         word = VRAM_W'($urandom_range(16'hffff));
         word[CODE_W-1:0] = GLYPH_CODES[$urandom_range(7)];
         send_beat(CMD_VRAM, ADDR_W'(a), word);
      end
   endtask

   // display off, side columns, inverted cursor cell, unused command, write then draw
   task automatic test_directed_pixels();
      // display still disabled from reset: black, raster keeps moving
      repeat (4) send_beat(CMD_TICK, '1, '1);
      wait_idle();
      program_regs(1'b1, 1'b0, 1'b0, 8'd255, 8'd255);
      repeat (6) send_beat(CMD_TICK, '0, '0);
      wait_idle();
      // invert video, cursor on cell 1 of row 0 drawn inverted
      program_regs(1'b1, 1'b1, 1'b0, 8'd1, 8'd0);
      repeat (10)
         send_beat(CMD_TICK, ADDR_W'($urandom_range(8191)),
                   VRAM_W'($urandom_range(16'hffff)));
      send_beat(CMD_NOP, '1, '1);
      // new word for cell 2 and a new glyph row right before it is drawn
      send_beat(CMD_VRAM, 13'd2, 16'hf9ff);
      send_beat(CMD_GLYPH, {9'd511, 4'b0000}, 16'hff81);
      repeat (3) send_beat(CMD_TICK, '0, '1);
      wait_idle();
   endtask

   // mixed traffic in four idling phases; the first one starts with a long rsp hold-off
   task automatic test_random_traffic();
      int gap_list   [4] = '{0, 58, 0, 14};
      int stall_list [4] = '{0, 0, 58, 14};
      int counted;
      int pick;
      logic [VRAM_W-1:0] d;
      logic [VRAM_W-1:0] word;
      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         random_regs();
         gap_pct   = gap_list[ph];
         stall_pct = stall_list[ph];
         // sender keeps offering while rsp is held, so the pipe fills and req stalls
         if (ph == 0)
            hold_left = 300;
         counted = 0;
         while (counted < 250) begin
            sender_gaps();
            pick = $urandom_range(99);
            d = VRAM_W'($urandom_range(16'hffff));
            if (pick < 60) begin
               send_beat(CMD_TICK, ADDR_W'($urandom_range(8191)), d);
               counted++;
            end else if (pick < 75) begin
               // screen words keep a known glyph code, words past the screen are free
               if ($urandom_range(1)) begin
                  word = d;
                  word[CODE_W-1:0] = GLYPH_CODES[$urandom_range(7)];
                  send_beat(CMD_VRAM, ADDR_W'($urandom_range(0, SCREEN_WORDS - 1)), word);
               end else begin
                  send_beat(CMD_VRAM, ADDR_W'($urandom_range(SCREEN_WORDS, 8191)), d);
               end
               counted++;
            end else if (pick < 90) begin
               send_beat(CMD_GLYPH, ADDR_W'($urandom_range(8191)), d);
               counted++;
            end else begin
               send_beat(CMD_NOP, ADDR_W'($urandom_range(8191)), d);
            end
         end
      end
      wait_idle();
      gap_pct   = 0;
      stall_pct = 0;
   endtask

   // run the raster through the end of the current scan line and into the next one
   task automatic test_line_end();
      int start_lines;
      int after_end;
      start_lines = lines_done;
      after_end = 0;
      while (lines_done == start_lines || after_end < 160) begin
         if (ras_pixel == 0 && $urandom_range(9) == 0) begin
            wait_idle();
            random_regs();
         end
         if (lines_done != start_lines)
            after_end++;
         send_beat(CMD_TICK, ADDR_W'($urandom_range(8191)), VRAM_W'($urandom_range(16'hffff)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_load_memories();
      test_directed_pixels();
      test_random_traffic();
      test_line_end();

      // final drain with its own bound
      req_valid <= 1'b0;
      for (int k = 0; k < 2000 && expected_pixels.size() != 0; k++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d pixel beats never arrived", expected_pixels.size());
         err_count++;
      end

      if (err_count == 0)
         $display("text_mode_pixel_generator_tb: done, clean");
      else
         $display("text_mode_pixel_generator_tb: done, errors");
      $finish;
   end

   // watchdog, several times the slowest clean run
   initial begin
      #2000000;
      $display("text_mode_pixel_generator_tb: done, errors");
      $finish;
   end

endmodule
